// ===== design/slfc_pkg.sv =====
package slfc_pkg;

	// Packet byte positions within one scan line
	localparam int POS_W = 6;
	typedef logic [POS_W-1:0] pos_t;

	localparam pos_t POS_MARK_FIRST = 6'd0;
	localparam pos_t POS_MARK_LAST  = 6'd9;
	localparam pos_t POS_VER        = 6'd10;
	localparam pos_t POS_TIME3      = 6'd11;
	localparam pos_t POS_TIME2      = 6'd12;
	localparam pos_t POS_TIME1      = 6'd13;
	localparam pos_t POS_TIME0      = 6'd14;
	localparam pos_t POS_INFO       = 6'd15;
	localparam pos_t POS_SWEEP1     = 6'd16;
	localparam pos_t POS_SWEEP0     = 6'd17;
	localparam pos_t POS_TURN1      = 6'd18;
	localparam pos_t POS_TURN0      = 6'd19;
	localparam pos_t POS_QUAT_FIRST = 6'd20;
	localparam pos_t POS_QUAT_LAST  = 6'd35;
	localparam pos_t POS_SAMP1      = 6'd36;
	localparam pos_t POS_SAMP0      = 6'd37;
	localparam pos_t POS_CRC3       = 6'd38;
	localparam pos_t POS_CRC2       = 6'd39;
	localparam pos_t POS_CRC1       = 6'd40;
	localparam pos_t POS_CRC0       = 6'd41;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 15;
	localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INFO    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LENGTH  = 2'd2;

	localparam logic [7:0]  VERSION_RST = 8'h08;
	localparam logic [7:0]  INFO_RST    = 8'hE1;
	localparam logic [14:0] LENGTH_RST  = 15'd2500;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

	// One classified sample request handed from front to back
	typedef struct packed {
		logic        first;
		logic        last;
		logic [15:0] sample;
		logic [31:0] time_mark;
		logic [15:0] sweep_angle;
		logic [15:0] turn_angle;
	} desc_t;

	// Reflected CRC-32, one byte
	function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== design/scan_line_framer_crc32_top.sv =====
// Scan-line packet framer with CRC-32.
// Input channel (in_valid / in_stall): one ADC sample per request, with the
// timestamp and angles that are used only on the first sample of a line.
// Output channel (out_valid / out_stall): one packet byte per request; a line
// starts with a 10-byte marker and a 26-byte header, each sample gives two
// big-endian bytes, and the last sample of a line adds the 4-byte CRC-32.
// end_of_packet marks the final CRC byte, last_of_run the last byte a sample gives.
// Config port (cfg_we / cfg_index / cfg_data): version_code, info_code and
// line_length; write only while no sample is in flight.
// A sample is written into the queue; its first byte is then loaded into the
// output register. Throughput is one byte per cycle while out_stall is low
// and a sample is queued: a mid-line sample gives 2 bytes, the first of a
// line 38, the last 6, a one-sample line 42. A small queue of samples sits
// between input and byte sequencer, so samples are taken while bytes drain.
// Reset: empty queue, line position zero, CRC all ones, registers at
// version 8, info 225, length 2500. A stalled output holds its byte; the
// queue fills and then in_stall rises.
module scan_line_framer_crc32_top import slfc_pkg::*; #(
	parameter int MAX_LINE_LENGTH = 16384,
	parameter int QUEUE_DEPTH     = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic signed [13:0]    sample,
	input  logic [31:0]           time_mark,
	input  logic [15:0]           sweep_angle,
	input  logic [15:0]           turn_angle,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            out_byte,
	output logic                  end_of_packet,
	output logic                  last_of_run,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [7:0]  version_q;
	logic [7:0]  info_q;
	logic [14:0] length_q;

	logic  push;
	logic  q_full;
	logic  q_not_empty;
	logic  pop;
	desc_t push_desc;
	desc_t head_desc;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version_q <= VERSION_RST;
			info_q    <= INFO_RST;
			length_q  <= LENGTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_VERSION: version_q <= cfg_data[7:0];
				CFG_INFO:    info_q    <= cfg_data[7:0];
				CFG_LENGTH:  length_q  <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	slfc_front #(
		.MAX_LINE_LENGTH(MAX_LINE_LENGTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample     (sample),
		.time_mark  (time_mark),
		.sweep_angle(sweep_angle),
		.turn_angle (turn_angle),
		.line_length(length_q),
		.q_full     (q_full),
		.push       (push),
		.desc       (push_desc)
	);

	slfc_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_data  (push_desc),
		.pop      (pop),
		.full     (q_full),
		.not_empty(q_not_empty),
		.rd_data  (head_desc)
	);

	slfc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (q_not_empty),
		.head         (head_desc),
		.pop          (pop),
		.version_code (version_q),
		.info_code    (info_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.end_of_packet(end_of_packet),
		.last_of_run  (last_of_run)
	);

endmodule

// ===== design/slfc_front.sv =====
module slfc_front import slfc_pkg::*; #(
	parameter int MAX_LINE_LENGTH = 16384
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [13:0] sample,
	input  logic [31:0]        time_mark,
	input  logic [15:0]        sweep_angle,
	input  logic [15:0]        turn_angle,
	input  logic [14:0]        line_length,
	input  logic               q_full,
	output logic               push,
	output desc_t              desc
);

	localparam int IDX_W = (MAX_LINE_LENGTH > 1) ? $clog2(MAX_LINE_LENGTH) : 1;
	localparam int CMP_W = ((IDX_W > 15) ? IDX_W : 15) + 2;
	localparam logic [CMP_W-1:0] MAX_LEN = CMP_W'(MAX_LINE_LENGTH);

	logic [IDX_W-1:0] idx_q;
	logic [CMP_W-1:0] len_eff;
	logic [CMP_W-1:0] idx_next;
	logic             is_last;

	// Clamp the programmed length into 1..MAX
	always_comb begin
		len_eff = CMP_W'(line_length);
		if (line_length == 15'd0) begin
			len_eff = CMP_W'(1);
		end else if (len_eff > MAX_LEN) begin
			len_eff = MAX_LEN;
		end
	end

	assign idx_next = CMP_W'(idx_q) + CMP_W'(1);
	assign is_last  = (idx_next >= len_eff);

	assign in_stall = q_full;
	assign push     = in_valid & ~q_full;

	// Classified request
	assign desc.first       = (idx_q == '0);
	assign desc.last        = is_last;
	assign desc.sample      = {{2{sample[13]}}, sample};
	assign desc.time_mark   = time_mark;
	assign desc.sweep_angle = sweep_angle;
	assign desc.turn_angle  = turn_angle;

	// Position of the next sample in its line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (push) begin
			idx_q <= is_last ? '0 : idx_next[IDX_W-1:0];
		end
	end

endmodule

// ===== design/slfc_queue.sv =====
module slfc_queue import slfc_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t wr_data,
	input  logic  pop,
	output logic  full,
	output logic  not_empty,
	output desc_t rd_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	desc_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign rd_data   = mem_q[rd_ptr_q];
	assign do_push   = push & ~full;
	assign do_pop    = pop & not_empty;

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== design/slfc_back.sv =====
module slfc_back import slfc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  desc_t      head,
	output logic       pop,
	input  logic [7:0] version_code,
	input  logic [7:0] info_code,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       end_of_packet,
	output logic       last_of_run
);

	logic        started_q;
	pos_t        pos_q;
	logic [31:0] crc_q;
	logic        out_valid_q;
	logic [7:0]  byte_q;
	logic        eop_q;
	logic        lor_q;

	pos_t        cur_pos;
	logic [7:0]  cur_byte;
	logic        in_crc;
	logic        byte_last;
	logic        advance;
	logic        load;
	logic [31:0] crc_base;
	logic [31:0] crc_fin;

	assign cur_pos = started_q ? pos_q : (head.first ? POS_MARK_FIRST : POS_SAMP1);
	assign crc_fin = ~crc_q;

	// Byte for the current position
	always_comb begin
		cur_byte = 8'd0;
		in_crc   = 1'b1;
		case (cur_pos) inside
			[POS_MARK_FIRST:POS_MARK_LAST]: begin
				cur_byte = {7'd0, cur_pos[0]};
				in_crc   = 1'b0;
			end
			POS_VER:    cur_byte = version_code;
			POS_TIME3:  cur_byte = head.time_mark[31:24];
			POS_TIME2:  cur_byte = head.time_mark[23:16];
			POS_TIME1:  cur_byte = head.time_mark[15:8];
			POS_TIME0:  cur_byte = head.time_mark[7:0];
			POS_INFO:   cur_byte = info_code;
			POS_SWEEP1: cur_byte = head.sweep_angle[15:8];
			POS_SWEEP0: cur_byte = head.sweep_angle[7:0];
			POS_TURN1:  cur_byte = head.turn_angle[15:8];
			POS_TURN0:  cur_byte = head.turn_angle[7:0];
			[POS_QUAT_FIRST:POS_QUAT_LAST]: cur_byte = 8'd0;
			POS_SAMP1:  cur_byte = head.sample[15:8];
			POS_SAMP0:  cur_byte = head.sample[7:0];
			POS_CRC3: begin
				cur_byte = crc_fin[31:24];
				in_crc   = 1'b0;
			end
			POS_CRC2: begin
				cur_byte = crc_fin[23:16];
				in_crc   = 1'b0;
			end
			POS_CRC1: begin
				cur_byte = crc_fin[15:8];
				in_crc   = 1'b0;
			end
			POS_CRC0: begin
				cur_byte = crc_fin[7:0];
				in_crc   = 1'b0;
			end
			default: begin
				cur_byte = 8'd0;
				in_crc   = 1'b0;
			end
		endcase
	end

	assign byte_last = (cur_pos == POS_CRC0) || ((cur_pos == POS_SAMP0) && !head.last);
	assign advance   = ~out_valid_q | ~out_stall;
	assign load      = advance & head_valid;
	assign pop       = load & byte_last;
	assign crc_base  = (cur_pos == POS_VER) ? CRC_INIT : crc_q;

	// Position sequencer and running CRC
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			pos_q     <= POS_MARK_FIRST;
			crc_q     <= CRC_INIT;
		end else if (load) begin
			started_q <= ~byte_last;
			pos_q     <= cur_pos + pos_t'(1);
			if (in_crc) begin
				crc_q <= crc_byte(crc_base, cur_byte);
			end else if (cur_pos == POS_CRC0) begin
				crc_q <= CRC_INIT;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= head_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= cur_byte;
			eop_q  <= (cur_pos == POS_CRC0);
			lor_q  <= byte_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_byte      = byte_q;
	assign end_of_packet = eop_q;
	assign last_of_run   = lor_q;

endmodule
